// ----- rtl/hse_pkg.sv -----
// hse_pkg: shared types, constants and the ordering function of the heap sort engine
// no dependencies; imported by hse_sequencer and heap_sort_engine
package hse_pkg;

    localparam int DATA_W = 32;

    // emission beat from the sequencer to the output register
    typedef struct packed {
        logic load;
        logic last;
    } hse_emit_t;

    // flip the sign bit so that an unsigned compare follows signed order
    function automatic logic [DATA_W-1:0] order_key(input logic [DATA_W-1:0] v);
        order_key = v ^ {1'b1, {(DATA_W-1){1'b0}}};
    endfunction

endpackage

// ----- rtl/heap_sort_engine.sv -----
// heap_sort_engine: top level, input capture, output register, memory and sequencer
// depends on hse_pkg, hse_heap_mem and hse_sequencer
//
//  channel | beat fields                                  | handshake
//  --------+----------------------------------------------+--------------------------
//  item    | item_value, item_last                        | item_valid / item_stall
//  sorted  | sorted_value, sorted_last, items_dropped     | sorted_valid / sorted_stall
//
// values load one per cycle; item_stall stays low until a beat with item_last arrives
// after that beat the sequencer owns the heap memory: each build sift reads and holds
//   its start value, then reads and compares the children one heap level at a time, and
//   ends when the held value is no smaller or it runs out of children; each root
//   extraction reads the root and the end value and swaps them before its sift
// read-out does one memory read and one load of the output register per result
//   and waits while the output register is full and stalled
// rst_n clears the fill count, the drop flag, the sequencer and the output valid;
//   heap contents are only read after being written in the current set
module heap_sort_engine
    import hse_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_stall,
    input  logic signed [DATA_W-1:0] item_value,
    input  logic                     item_last,
    output logic                     sorted_valid,
    input  logic                     sorted_stall,
    output logic signed [DATA_W-1:0] sorted_value,
    output logic                     sorted_last,
    output logic                     items_dropped
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]     count_reg, count_next;
    logic              overflow_reg, overflow_next;
    logic              sorted_valid_reg, sorted_valid_next;
    logic [DATA_W-1:0] sorted_value_reg;
    logic              sorted_last_reg;
    logic              items_dropped_reg;

    logic              in_beat;
    logic              has_room;
    logic              start;
    logic [CW-1:0]     n_start;
    logic              out_free;
    logic              seq_busy;

    logic              seq_we;
    logic [AW-1:0]     seq_waddr;
    logic [DATA_W-1:0] seq_wdata;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]     rd_a_addr;
    logic [AW-1:0]     rd_b_addr;
    logic [DATA_W-1:0] rd_a_data;
    logic [DATA_W-1:0] rd_b_data;
    hse_emit_t         emit;
    logic [DATA_W-1:0] emit_value;

    // input is taken only while the sequencer is idle
    assign item_stall = seq_busy;
    assign in_beat    = item_valid && !seq_busy;
    assign has_room   = count_reg < CW'(CAPACITY);
    assign start      = in_beat && item_last;
    assign n_start    = has_room ? (count_reg + CW'(1)) : CW'(CAPACITY);

    // output register frees when empty or when its beat is taken this cycle
    assign out_free = !sorted_valid_reg || !sorted_stall;

    // memory write port: input beats while idle, sequencer otherwise
    assign mem_we    = seq_busy ? seq_we : (in_beat && has_room);
    assign mem_waddr = seq_busy ? seq_waddr : count_reg[AW-1:0];
    assign mem_wdata = seq_busy ? seq_wdata : item_value;

    always_comb
    begin
        count_next        = count_reg;
        overflow_next     = overflow_reg;
        sorted_valid_next = sorted_valid_reg;

        if (in_beat)
        begin
            if (has_room)
            begin
                count_next = count_reg + CW'(1);
            end
            else
            begin
                overflow_next = 1'b1;
            end
        end

        // set ends when its final result goes into the output register
        if (emit.load && emit.last)
        begin
            count_next    = '0;
            overflow_next = 1'b0;
        end

        if (emit.load)
        begin
            sorted_valid_next = 1'b1;
        end
        else if (!sorted_stall)
        begin
            sorted_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            overflow_reg     <= 1'b0;
            sorted_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            overflow_reg     <= overflow_next;
            sorted_valid_reg <= sorted_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.load)
        begin
            sorted_value_reg  <= emit_value;
            sorted_last_reg   <= emit.last;
            items_dropped_reg <= overflow_reg;
        end
    end

    assign sorted_valid  = sorted_valid_reg;
    assign sorted_value  = sorted_value_reg;
    assign sorted_last   = sorted_last_reg;
    assign items_dropped = items_dropped_reg;

    hse_heap_mem #(
        .DEPTH  (CAPACITY),
        .AW     (AW),
        .DATA_W (DATA_W)
    ) u_heap_mem (
        .clk       (clk),
        .we        (mem_we),
        .waddr     (mem_waddr),
        .wdata     (mem_wdata),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data)
    );

    hse_sequencer #(
        .AW (AW),
        .CW (CW)
    ) u_sequencer (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .n_start    (n_start),
        .out_free   (out_free),
        .busy       (seq_busy),
        .we         (seq_we),
        .waddr      (seq_waddr),
        .wdata      (seq_wdata),
        .rd_a_addr  (rd_a_addr),
        .rd_b_addr  (rd_b_addr),
        .rd_a_data  (rd_a_data),
        .rd_b_data  (rd_b_data),
        .emit       (emit),
        .emit_value (emit_value)
    );

endmodule

// ----- rtl/hse_heap_mem.sv -----
// hse_heap_mem: heap storage, one write port and two registered read ports
// no dependencies; instantiated by heap_sort_engine
module hse_heap_mem #(
    parameter int DEPTH  = 64,
    parameter int AW     = 6,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [AW-1:0]     rd_a_addr,
    input  logic [AW-1:0]     rd_b_addr,
    output logic [DATA_W-1:0] rd_a_data,
    output logic [DATA_W-1:0] rd_b_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_a_data <= mem[rd_a_addr];
        rd_b_data <= mem[rd_b_addr];
    end

endmodule

// ----- rtl/hse_sequencer.sv -----
// hse_sequencer: heap build, root extraction and in-order read-out over the heap memory
// depends on hse_pkg; drives hse_heap_mem through heap_sort_engine
module hse_sequencer
    import hse_pkg::*;
#(
    parameter int AW = 6,
    parameter int CW = 7
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [CW-1:0]     n_start,
    input  logic              out_free,
    output logic              busy,
    output logic              we,
    output logic [AW-1:0]     waddr,
    output logic [DATA_W-1:0] wdata,
    output logic [AW-1:0]     rd_a_addr,
    output logic [AW-1:0]     rd_b_addr,
    input  logic [DATA_W-1:0] rd_a_data,
    input  logic [DATA_W-1:0] rd_b_data,
    output hse_emit_t         emit,
    output logic [DATA_W-1:0] emit_value
);

    // heap positions are 1-based; a child position can reach twice the depth
    localparam int PW = AW + 2;

    localparam logic [3:0] ST_IDLE       = 4'd0;
    localparam logic [3:0] ST_BUILD_RD   = 4'd1;
    localparam logic [3:0] ST_BUILD_HELD = 4'd2;
    localparam logic [3:0] ST_CHILD_RD   = 4'd3;
    localparam logic [3:0] ST_CHILD_CMP  = 4'd4;
    localparam logic [3:0] ST_SORT_RD    = 4'd5;
    localparam logic [3:0] ST_SORT_SWAP  = 4'd6;
    localparam logic [3:0] ST_EMIT_RD    = 4'd7;
    localparam logic [3:0] ST_EMIT_LD    = 4'd8;

    logic [3:0]        state_reg,  state_next;
    logic [CW-1:0]     n_reg,      n_next;
    logic [CW-1:0]     i_reg,      i_next;
    logic [CW-1:0]     limit_reg,  limit_next;
    logic [CW-1:0]     k_reg,      k_next;
    logic [PW-1:0]     top_reg,    top_next;
    logic [DATA_W-1:0] held_reg,   held_next;
    logic              sort_phase_reg, sort_phase_next;

    logic [PW-1:0]     child;
    logic [PW-1:0]     limit_ext;
    logic [PW-1:0]     top_m1;
    logic              right_ok;
    logic              take_right;
    logic [DATA_W-1:0] big_value;
    logic [PW-1:0]     big_pos;
    logic              sift_end;

    assign child     = {top_reg[PW-2:0], 1'b0};
    assign limit_ext = PW'(limit_reg);
    assign top_m1    = top_reg - PW'(1);
    assign right_ok  = child < limit_ext;
    assign take_right = right_ok && (order_key(rd_a_data) < order_key(rd_b_data));
    assign big_value = take_right ? rd_b_data : rd_a_data;
    assign big_pos   = take_right ? (child + PW'(1)) : child;
    assign busy      = state_reg != ST_IDLE;
    assign emit_value = rd_a_data;

    always_comb
    begin
        state_next      = state_reg;
        n_next          = n_reg;
        i_next          = i_reg;
        limit_next      = limit_reg;
        k_next          = k_reg;
        top_next        = top_reg;
        held_next       = held_reg;
        sort_phase_next = sort_phase_reg;
        we              = 1'b0;
        waddr           = top_m1[AW-1:0];
        wdata           = held_reg;
        rd_a_addr       = '0;
        rd_b_addr       = '0;
        emit            = '0;
        sift_end        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    n_next          = n_start;
                    sort_phase_next = 1'b0;
                    k_next          = '0;
                    if (n_start > CW'(1))
                    begin
                        i_next     = n_start >> 1;
                        state_next = ST_BUILD_RD;
                    end
                    else
                    begin
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            ST_BUILD_RD:
            begin
                rd_a_addr  = AW'(i_reg - CW'(1));
                state_next = ST_BUILD_HELD;
            end
            ST_BUILD_HELD:
            begin
                held_next  = rd_a_data;
                top_next   = PW'(i_reg);
                limit_next = n_reg;
                state_next = ST_CHILD_RD;
            end
            ST_CHILD_RD:
            begin
                if (child > limit_ext)
                begin
                    // no children left: the held value settles here
                    we       = 1'b1;
                    sift_end = 1'b1;
                end
                else
                begin
                    rd_a_addr  = AW'(child - PW'(1));
                    rd_b_addr  = right_ok ? AW'(child) : AW'(child - PW'(1));
                    state_next = ST_CHILD_CMP;
                end
            end
            ST_CHILD_CMP:
            begin
                we = 1'b1;
                if (order_key(held_reg) >= order_key(big_value))
                begin
                    sift_end = 1'b1;
                end
                else
                begin
                    wdata      = big_value;
                    top_next   = big_pos;
                    state_next = ST_CHILD_RD;
                end
            end
            ST_SORT_RD:
            begin
                rd_a_addr  = '0;
                rd_b_addr  = AW'(i_reg - CW'(1));
                state_next = ST_SORT_SWAP;
            end
            ST_SORT_SWAP:
            begin
                // root goes to the end; the old end value sifts from the root
                we         = 1'b1;
                waddr      = AW'(i_reg - CW'(1));
                wdata      = rd_a_data;
                held_next  = rd_b_data;
                top_next   = PW'(1);
                limit_next = i_reg - CW'(1);
                state_next = ST_CHILD_RD;
            end
            ST_EMIT_RD:
            begin
                rd_a_addr = AW'(k_reg);
                if (out_free)
                begin
                    state_next = ST_EMIT_LD;
                end
            end
            ST_EMIT_LD:
            begin
                emit.load = 1'b1;
                emit.last = k_reg == (n_reg - CW'(1));
                if (emit.last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    k_next     = k_reg + CW'(1);
                    state_next = ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (sift_end)
        begin
            if (!sort_phase_reg)
            begin
                if (i_reg > CW'(1))
                begin
                    i_next     = i_reg - CW'(1);
                    state_next = ST_BUILD_RD;
                end
                else
                begin
                    sort_phase_next = 1'b1;
                    i_next          = n_reg;
                    state_next      = ST_SORT_RD;
                end
            end
            else
            begin
                if (i_reg > CW'(2))
                begin
                    i_next     = i_reg - CW'(1);
                    state_next = ST_SORT_RD;
                end
                else
                begin
                    k_next     = '0;
                    state_next = ST_EMIT_RD;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sort_phase_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sort_phase_reg <= sort_phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        i_reg     <= i_next;
        limit_reg <= limit_next;
        k_reg     <= k_next;
        top_reg   <= top_next;
        held_reg  <= held_next;
    end

endmodule

// ----- rtl/hse_checker.sv -----
// hse_checker: port-level checks on heap_sort_engine, attached by bind
// no package dependency; watches the top level ports only
module hse_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_stall,
    input logic               item_last,
    input logic               sorted_valid,
    input logic               sorted_stall,
    input logic signed [31:0] sorted_value,
    input logic               sorted_last
);

    logic               out_beat;
    logic               have_prev_reg;
    logic signed [31:0] prev_reg;

    assign out_beat = sorted_valid && !sorted_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
        end
        else if (out_beat)
        begin
            have_prev_reg <= !sorted_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_beat)
        begin
            prev_reg <= sorted_value;
        end
    end

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        sorted_valid && sorted_stall |=> sorted_valid && $stable(sorted_value))
        else $error("stalled result beat changed");

    // the final item of a set starts the sort, so input stalls next cycle
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && item_last |=> item_stall)
        else $error("input not stalled after final item");

    // results within a set come out in ascending order
    a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat && have_prev_reg |-> sorted_value >= prev_reg)
        else $error("results out of order");

    // nothing follows the final result in the next cycle
    a_set_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat && sorted_last |=> !sorted_valid)
        else $error("result beat after final result");

    // while a set is still being read out no new item is taken
    a_no_input_midset: assert property (@(posedge clk) disable iff (!rst_n)
        sorted_valid && !sorted_last |-> item_stall)
        else $error("input taken during read-out");

endmodule

bind heap_sort_engine hse_checker u_hse_checker (.*);
